// ===== rtl/sspc_pkg.sv =====
package sspc_pkg;

  // Packet geometry.
  localparam int MAX_PACKET_BYTES_DEF = 13;
  localparam int MAX_RUN              = 7;
  localparam int PIDX_W               = 3;
  localparam int PARAM_POS            = 3;
  localparam int LEN_W                = 9;
  localparam int QUEUE_DEPTH          = 2;

  localparam logic [7:0] HEADER_BYTE = 8'hFF;
  localparam logic [7:0] SUM_GOOD    = 8'hFF;

  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_IDLE = 1'b1
  } cmd_t;

  // Everything the back end needs to emit the run of one closed packet.
  typedef struct packed {
    logic                           found;
    logic [7:0]                     sid;
    logic [7:0]                     dstat;
    logic                           header_bad;
    logic                           length_bad;
    logic                           checksum_bad;
    logic                           id_mismatch;
    logic [PIDX_W-1:0]              nparams;
    logic [MAX_RUN-1:0][7:0]        params;
  } summary_t;

endpackage

// ===== rtl/sspc_ifs.sv =====
interface sspc_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] rx_byte;

  modport source (output valid, output command, output rx_byte, input ready);
  modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

interface sspc_out_if;
  logic       valid;
  logic       ready;
  logic       packet_found;
  logic [7:0] reply_id;
  logic [7:0] device_status;
  logic       header_bad;
  logic       length_bad;
  logic       checksum_bad;
  logic       id_mismatch;
  logic       param_valid;
  logic [2:0] param_index;
  logic [7:0] param_byte;
  logic       last;

  modport source (output valid, output packet_found, output reply_id, output device_status,
                  output header_bad, output length_bad, output checksum_bad,
                  output id_mismatch, output param_valid, output param_index,
                  output param_byte, output last, input ready);
  modport sink   (input valid, input packet_found, input reply_id, input device_status,
                  input header_bad, input length_bad, input checksum_bad,
                  input id_mismatch, input param_valid, input param_index,
                  input param_byte, input last, output ready);
endinterface

interface sspc_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/sspc_front.sv =====
module sspc_front #(
  parameter int MAX_PACKET_BYTES = sspc_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  sspc_in_if.sink           req,
  sspc_cfg_if.sink          cfg,
  output logic              push,
  output sspc_pkg::summary_t push_data,
  input  logic              full
);
  import sspc_pkg::*;

  localparam int CW = $clog2(MAX_PACKET_BYTES + 1);

  logic [CW-1:0]           byte_count, byte_count_next;
  logic [CW-1:0]           ff_count, ff_count_next;
  logic                    in_header, in_header_next;
  logic [7:0]              sid, sid_next;
  logic [7:0]              len, len_next;
  logic [7:0]              dstat, dstat_next;
  logic [7:0]              sum, sum_next;
  logic [MAX_RUN-1:0][7:0] params, params_next;
  logic [7:0]              expected_id;

  logic                    accept;
  logic                    take_byte;
  logic [CW-1:0]           pos;
  logic [CW-1:0]           rest;
  logic [LEN_W-1:0]        over;

  assign req.ready = !full;
  assign cfg.ready = 1'b1;
  assign accept    = req.valid && req.ready;
  assign take_byte = accept && (req.command == CMD_BYTE) &&
                     (byte_count < CW'(MAX_PACKET_BYTES));
  assign pos       = byte_count - ff_count;

  always_comb begin
    byte_count_next = byte_count;
    ff_count_next   = ff_count;
    in_header_next  = in_header;
    sid_next        = sid;
    len_next        = len;
    dstat_next      = dstat;
    sum_next        = sum;
    params_next     = params;
    push            = 1'b0;
    push_data       = '0;
    rest            = '0;
    over            = '0;

    if (take_byte) begin
      byte_count_next = byte_count + CW'(1);
      if (in_header && req.rx_byte == HEADER_BYTE) begin
        ff_count_next = ff_count + CW'(1);
      end else begin
        in_header_next = 1'b0;
        if (pos == CW'(0)) sid_next = req.rx_byte;
        if (pos == CW'(1)) len_next = req.rx_byte;
        if (pos == CW'(2)) dstat_next = req.rx_byte;
        for (int j = 0; j < MAX_RUN; j++) begin
          if (LEN_W'(pos) == LEN_W'(j + PARAM_POS)) params_next[j] = req.rx_byte;
        end
        // The checksum covers id onwards for length-plus-two bytes.
        if (LEN_W'(pos) < LEN_W'(2) || LEN_W'(pos) < LEN_W'(len) + LEN_W'(2)) begin
          sum_next = sum + req.rx_byte;
        end
      end
    end

    if (accept && (req.command == CMD_IDLE || byte_count_next == CW'(MAX_PACKET_BYTES))) begin
      push = 1'b1;
      rest = byte_count_next - ff_count_next;
      if (rest != '0) begin
        push_data.found        = 1'b1;
        push_data.sid          = sid_next;
        push_data.dstat        = dstat_next;
        push_data.header_bad   = (ff_count_next != CW'(2));
        push_data.length_bad   = (LEN_W'(rest) != LEN_W'(len_next) + LEN_W'(2));
        push_data.checksum_bad = (sum_next != SUM_GOOD);
        push_data.id_mismatch  = (sid_next != expected_id);
        push_data.params       = params_next;
        if (LEN_W'(rest) > LEN_W'(4)) begin
          over = LEN_W'(rest) - LEN_W'(4);
          push_data.nparams = (over > LEN_W'(MAX_RUN)) ? PIDX_W'(MAX_RUN) : over[PIDX_W-1:0];
        end
      end
      byte_count_next = '0;
      ff_count_next   = '0;
      in_header_next  = 1'b1;
      sid_next        = '0;
      len_next        = '0;
      dstat_next      = '0;
      sum_next        = '0;
    end
  end

  always_ff @(posedge clk) begin
    params <= params_next;
    if (rst) begin
      byte_count  <= '0;
      ff_count    <= '0;
      in_header   <= 1'b1;
      sid         <= '0;
      len         <= '0;
      dstat       <= '0;
      sum         <= '0;
      expected_id <= 8'd1;
    end else begin
      byte_count <= byte_count_next;
      ff_count   <= ff_count_next;
      in_header  <= in_header_next;
      sid        <= sid_next;
      len        <= len_next;
      dstat      <= dstat_next;
      sum        <= sum_next;
      if (cfg.valid && cfg.ready) begin
        expected_id <= cfg.data;
      end
    end
  end

endmodule

// ===== rtl/sspc_queue.sv =====
module sspc_queue #(
  parameter int DEPTH = sspc_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  sspc_pkg::summary_t push_data,
  output logic               full,
  input  logic               pop,
  output sspc_pkg::summary_t head,
  output logic               empty
);
  import sspc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  summary_t      slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] fill;
  logic          do_push;
  logic          do_pop;

  assign full    = (fill == NW'(DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      fill <= fill + NW'(do_push) - NW'(do_pop);
    end
  end

endmodule

// ===== rtl/sspc_back.sv =====
module sspc_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               empty,
  input  sspc_pkg::summary_t head,
  output logic               pop,
  sspc_out_if.source         rsp
);
  import sspc_pkg::*;

  logic [PIDX_W-1:0] k;
  logic              has_params;
  logic              is_last;
  logic              fire;

  assign has_params = (head.nparams != '0);
  assign is_last    = !has_params || (k == head.nparams - PIDX_W'(1));
  assign fire       = rsp.valid && rsp.ready;
  assign pop        = fire && is_last;

  assign rsp.valid         = !empty;
  assign rsp.packet_found  = head.found;
  assign rsp.reply_id      = head.sid;
  assign rsp.device_status = head.dstat;
  assign rsp.header_bad    = head.header_bad;
  assign rsp.length_bad    = head.length_bad;
  assign rsp.checksum_bad  = head.checksum_bad;
  assign rsp.id_mismatch   = head.id_mismatch;
  assign rsp.param_valid   = has_params;
  assign rsp.param_index   = has_params ? k : '0;
  assign rsp.param_byte    = has_params ? head.params[k] : '0;
  assign rsp.last          = is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (fire) begin
      k <= is_last ? '0 : k + PIDX_W'(1);
    end
  end

endmodule

// ===== rtl/servo_status_packet_checker_top.sv =====
// Latency: a byte word is absorbed in the cycle it is accepted; if the queue was empty, the
// first result word of a closed packet is offered on the cycle after the close is accepted.
// Throughput: one input word per cycle while the two-entry summary queue has room; a close
// emits its one to seven result words from the queue head, one per cycle while rsp is ready.
// Reset: synchronous rst empties the queue, clears the packet counters and sums, re-arms
// header detection and sets expected_id to 1.
module servo_status_packet_checker_top #(
  parameter int MAX_PACKET_BYTES = sspc_pkg::MAX_PACKET_BYTES_DEF
) (
  input logic       clk,
  input logic       rst,
  sspc_in_if.sink   req,
  sspc_cfg_if.sink  cfg,
  sspc_out_if.source rsp
);
  import sspc_pkg::*;

  // The front end tracks the packet as bytes arrive, so that at close the whole
  // summary, including the parameter bytes, is ready in the cycle of the closing word.
  summary_t push_data;
  summary_t head;
  logic     push;
  logic     full;
  logic     pop;
  logic     empty;

  sspc_front #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg       (cfg),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  // The queue lets new bytes be taken while an earlier packet's run still drains.
  sspc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  // The back end walks the head packet's parameter bytes, one word per cycle while ready.
  sspc_back u_back (
    .clk   (clk),
    .rst   (rst),
    .empty (empty),
    .head  (head),
    .pop   (pop),
    .rsp   (rsp)
  );

endmodule

// ===== tb/sv/tb_servo_status_packet_checker_top.sv =====
`timescale 1ns / 100ps

module tb_servo_status_packet_checker_top;
  import sspc_pkg::*;

  // Packet geometry and the timing knobs of the run.
  localparam int PACKET_BYTES    = MAX_PACKET_BYTES_DEF;
  localparam int HEADER_LEN      = 2;     // a proper header is exactly two 0xFF bytes
  localparam int FIXED_FIELDS    = 4;     // id, length, status and checksum
  localparam int MAX_GAP         = 16;
  localparam int SETTLE_CYCLES   = 4;     // quiet cycles before a register write
  localparam int DRAIN_CYCLES    = 16;    // quiet cycles before the verdict
  localparam int PRESSURE_CYCLES = 400;   // long receiver hold-off
  localparam int PHASE_WORDS     = 58;

  // One result word as the receiver sees it.
  typedef struct packed {
    logic       found;
    logic [7:0] sid;
    logic [7:0] dstat;
    logic       header_bad;
    logic       length_bad;
    logic       checksum_bad;
    logic       id_mismatch;
    logic       param_valid;
    logic [2:0] param_index;
    logic [7:0] param_byte;
    logic       last;
  } status_word_t;

  typedef logic [7:0] byte_q_t[$];

  // The scoreboard keeps its own copy of the packet being collected and of
  // expected_id. Each accepted input word is folded into that copy; a close
  // turns it into the run of result words that the block must produce.
  class status_scoreboard;
    logic [7:0]   stored[PACKET_BYTES];
    int unsigned  byte_count;
    int unsigned  ff_count;
    bit           in_header;
    logic [7:0]   expected_id;
    status_word_t awaited[$];
    int unsigned  errors;
    int unsigned  results_checked;
    int unsigned  packets_closed;

    function new();
      byte_count  = 0;
      ff_count    = 0;
      in_header   = 1'b1;
      expected_id = 8'd1;
      errors      = 0;
      results_checked = 0;
      packets_closed  = 0;
    endfunction

    function void set_expected_id(logic [7:0] value);
      expected_id = value;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    // Positions never received read as zero.
    function logic [7:0] stored_at(int unsigned pos);
      if (pos < byte_count) return stored[pos];
      return 8'h00;
    endfunction

    function void close_packet();
      int unsigned  rest;
      int unsigned  start;
      int unsigned  len_total;
      int unsigned  nparams;
      int unsigned  k;
      logic [7:0]   sum;
      logic [7:0]   sid;
      logic [7:0]   dstat;
      status_word_t w;
      packets_closed++;
      rest = byte_count - ff_count;
      w = '0;
      if (rest == 0) begin
        w.last = 1'b1;
        awaited.push_back(w);
      end else begin
        start = ff_count;
        sid   = stored_at(start);
        dstat = stored_at(start + 2);
        len_total = 2 + stored_at(start + 1);
        sum = 8'h00;
        for (int unsigned f = 0; f < len_total; f++) sum = sum + stored_at(start + f);
        nparams = (rest > FIXED_FIELDS) ? rest - FIXED_FIELDS : 0;
        if (nparams > MAX_RUN) nparams = MAX_RUN;
        k = 0;
        do begin
          w = '0;
          w.found        = 1'b1;
          w.sid          = sid;
          w.dstat        = dstat;
          w.header_bad   = (ff_count != HEADER_LEN);
          w.length_bad   = (rest != len_total);
          w.checksum_bad = (sum != SUM_GOOD);
          w.id_mismatch  = (sid != expected_id);
          if (nparams > 0) begin
            w.param_valid = 1'b1;
            w.param_index = 3'(k);
            w.param_byte  = stored_at(start + PARAM_POS + k);
          end
          k++;
          w.last = (k >= nparams);
          awaited.push_back(w);
        end while (k < nparams);
      end
      byte_count = 0;
      ff_count   = 0;
      in_header  = 1'b1;
    endfunction

    function void note_input(cmd_t cmd, logic [7:0] value);
      if (cmd == CMD_IDLE) begin
        close_packet();
        return;
      end
      if (byte_count < PACKET_BYTES) begin
        stored[byte_count] = value;
        byte_count++;
        if (in_header && value == HEADER_BYTE) ff_count++;
        else in_header = 1'b0;
      end
      if (byte_count >= PACKET_BYTES) close_packet();
    endfunction

    function void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected %0h, got %0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(status_word_t got);
      status_word_t want;
      if (awaited.size() == 0) begin
        $error("result word arrived with nothing expected");
        errors++;
        return;
      end
      want = awaited.pop_front();
      results_checked++;
      check_field("packet_found",  8'(want.found),        8'(got.found));
      check_field("reply_id",      want.sid,              got.sid);
      check_field("device_status", want.dstat,            got.dstat);
      check_field("header_bad",    8'(want.header_bad),   8'(got.header_bad));
      check_field("length_bad",    8'(want.length_bad),   8'(got.length_bad));
      check_field("checksum_bad",  8'(want.checksum_bad), 8'(got.checksum_bad));
      check_field("id_mismatch",   8'(want.id_mismatch),  8'(got.id_mismatch));
      check_field("param_valid",   8'(want.param_valid),  8'(got.param_valid));
      check_field("param_index",   8'(want.param_index),  8'(got.param_index));
      check_field("param_byte",    want.param_byte,       got.param_byte);
      check_field("last",          8'(want.last),         8'(got.last));
    endfunction
  endclass

  logic clk;
  logic rst;

  sspc_in_if  req();
  sspc_cfg_if cfg();
  sspc_out_if rsp();

  servo_status_packet_checker_top dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cfg (cfg),
    .rsp (rsp)
  );

  status_scoreboard board = new();

  // Run-wide counters and the switches that shape the idling on each side.
  int unsigned words_sent      = 0;
  int unsigned idle_words      = 0;
  int unsigned settings_done   = 0;
  int unsigned hold_off_cycles = 0;
  bit          req_no_gaps     = 1'b0;
  bit          rsp_no_gaps     = 1'b0;

  // 12 ns clock.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Each side draws a fresh wait for every word. A quarter of the draws are
  // forced to zero so that back-to-back words are common even outside the
  // phases that switch idling off altogether.
  function automatic int draw_gap(bit no_gaps);
    if (no_gaps) return 0;
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  // Offers one input word and returns at the edge where it is accepted. The
  // scoreboard is told about the word in that same time step, which is before
  // any result of it can appear on the output side.
  task automatic send_word(cmd_t cmd, logic [7:0] value);
    int gap;
    gap = draw_gap(req_no_gaps);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid   <= 1'b1;
    req.command <= cmd;
    req.rx_byte <= value;
    do @(posedge clk); while (req.ready !== 1'b1);
    board.note_input(cmd, value);
    words_sent++;
    if (cmd == CMD_IDLE) idle_words++;
  endtask

  task automatic send_bytes(byte_q_t pkt);
    foreach (pkt[i]) send_word(CMD_BYTE, pkt[i]);
  endtask

  task automatic send_idle();
    send_word(CMD_IDLE, 8'($urandom));
  endtask

  // Builds a status packet. With no skew and no flip it is well formed: the
  // length field counts parameters plus two and the checksum completes the
  // sum to 0xFF. A skew or a flip breaks the matching check on purpose.
  function automatic byte_q_t make_status(int unsigned n_ff, logic [7:0] id,
                                          int unsigned n_par, int len_skew,
                                          logic [7:0] sum_flip);
    byte_q_t    pkt;
    logic [7:0] len;
    logic [7:0] stat;
    logic [7:0] sum;
    logic [7:0] p;
    repeat (n_ff) pkt.push_back(HEADER_BYTE);
    len  = 8'(int'(n_par) + 2 + len_skew);
    stat = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom);
    sum  = id + len + stat;
    pkt.push_back(id);
    pkt.push_back(len);
    pkt.push_back(stat);
    repeat (n_par) begin
      p = 8'($urandom);
      sum = sum + p;
      pkt.push_back(p);
    end
    pkt.push_back(~sum ^ sum_flip);
    return pkt;
  endfunction

  // Registers are only touched while nothing is in flight: the input side is
  // quiet, every expected result word has been taken, and a settling wait has
  // passed for anything the block might still be working on.
  task automatic write_expected_id(logic [7:0] value);
    req.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg.data  <= value;
    cfg.valid <= 1'b1;
    do @(posedge clk); while (cfg.ready !== 1'b1);
    cfg.valid <= 1'b0;
    board.set_expected_id(value);
    settings_done++;
  endtask

  // Random traffic. Most of it is status packets with random content, since
  // only those get past the header and into the length, checksum and id
  // checks; the rest is noise, lone timeouts and packets cut short. The
  // phase always ends with a timeout so that no packet is left half built
  // across a register write.
  task automatic run_traffic(int unsigned n_words);
    int unsigned start_count;
    int unsigned pick;
    int unsigned n_ff;
    int unsigned n_par;
    int          skew;
    logic [7:0]  id;
    logic [7:0]  flip;
    byte_q_t     pkt;
    start_count = words_sent;
    while (words_sent - start_count < n_words) begin
      pick = $urandom_range(0, 99);
      if (pick < 70 || pick >= 95) begin
        n_ff  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4) : HEADER_LEN;
        id    = ($urandom_range(0, 3) != 0) ? board.expected_id : 8'($urandom);
        n_par = $urandom_range(0, MAX_RUN);
        skew  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
        flip  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
        pkt   = make_status(n_ff, id, n_par, skew, flip);
        // A broken packet loses its tail before the line goes idle.
        if (pick >= 95) pkt = pkt[0 : $urandom_range(0, pkt.size() - 1)];
        send_bytes(pkt);
        if ($urandom_range(0, 9) != 0) send_idle();
      end else if (pick < 85) begin
        repeat ($urandom_range(1, PACKET_BYTES + 1)) begin
          if ($urandom_range(0, 2) == 0) send_word(CMD_BYTE, HEADER_BYTE);
          else send_word(CMD_BYTE, 8'($urandom));
        end
        if ($urandom_range(0, 1) == 0) send_idle();
      end else begin
        send_idle();
      end
    end
    send_idle();
  endtask

  // Result side: takes one word at a time after its own random stall and
  // hands it to the scoreboard. A hold-off request from the stimulus makes it
  // keep ready low for a long stretch, counted here in cycles.
  initial begin : result_sink
    status_word_t got;
    int           gap;
    rsp.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_off_cycles > 0) begin
        rsp.ready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end
      gap = draw_gap(rsp_no_gaps);
      if (gap > 0) begin
        rsp.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (rsp.valid !== 1'b1);
      got.found        = rsp.packet_found;
      got.sid          = rsp.reply_id;
      got.dstat        = rsp.device_status;
      got.header_bad   = rsp.header_bad;
      got.length_bad   = rsp.length_bad;
      got.checksum_bad = rsp.checksum_bad;
      got.id_mismatch  = rsp.id_mismatch;
      got.param_valid  = rsp.param_valid;
      got.param_index  = rsp.param_index;
      got.param_byte   = rsp.param_byte;
      got.last         = rsp.last;
      board.check_result(got);
    end
  end

  // Main stimulus.
  initial begin : stimulus
    byte_q_t    pkt;
    logic [7:0] mid_id;
    rst         <= 1'b1;
    req.valid   <= 1'b0;
    req.command <= CMD_BYTE;
    req.rx_byte <= 8'h00;
    cfg.valid   <= 1'b0;
    cfg.data    <= 8'h00;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part, with expected_id still at its reset value of one.
    // A timeout on an empty packet: nothing after the header at all.
    send_idle();
    // Only 0xFF bytes before the timeout, and three of them.
    pkt = '{8'hFF, 8'hFF, 8'hFF};
    send_bytes(pkt);
    send_idle();
    // A clean packet with no parameter bytes: 01 + 02 + 80 + 7C sums to FF.
    pkt = '{8'hFF, 8'hFF, 8'h01, 8'h02, 8'h80, 8'h7C};
    send_bytes(pkt);
    send_idle();
    // Thirteen bytes with no header: the last one closes the packet by itself,
    // the length field of FF cannot match, and the parameter run is capped.
    pkt = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01,
            8'h80, 8'h7F, 8'hFE, 8'h02, 8'h40, 8'h10};
    send_bytes(pkt);
    // A one-byte header and a packet cut short after the id: the length,
    // status and checksum were never received and read as zero.
    pkt = '{8'hFF, 8'h01};
    send_bytes(pkt);
    send_idle();

    // Random phases, each with its own expected_id, the values 0 and 254 first.
    write_expected_id(8'd0);
    run_traffic(PHASE_WORDS);

    write_expected_id(8'd254);
    run_traffic(PHASE_WORDS);

    mid_id = 8'($urandom_range(2, 253));
    write_expected_id(mid_id);
    run_traffic(PHASE_WORDS);

    // A stretch with no idling on either side.
    write_expected_id(8'd1);
    req_no_gaps = 1'b1;
    rsp_no_gaps = 1'b1;
    run_traffic(PHASE_WORDS);
    rsp_no_gaps = 1'b0;

    // Back pressure: the receiver stops taking words for a long while and the
    // sender keeps offering timeouts and short packets, so the summary queue
    // fills and the input side has to stall.
    mid_id = 8'($urandom_range(0, 254));
    write_expected_id(mid_id);
    hold_off_cycles = PRESSURE_CYCLES;
    repeat (12) send_idle();
    pkt = make_status(HEADER_LEN, mid_id, 0, 0, 8'h00);
    repeat (3) begin
      send_bytes(pkt);
      send_idle();
    end
    req_no_gaps = 1'b0;
    run_traffic(PHASE_WORDS);

    // Let the last result words drain, then allow a little longer so that a
    // stray extra word would still be caught.
    req.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d input words (%0d timeouts), %0d packets closed, %0d result words.",
             words_sent, idle_words, board.packets_closed, board.results_checked);
    $display("Used %0d expected_id settings and one %0d-cycle receiver hold-off.",
             settings_done + 1, PRESSURE_CYCLES);
    if (board.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Safety net: well beyond the slowest correct run.
  initial begin : watchdog
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
